[rtl/landmark_mahalanobis_distance_assert.svh]
// assertion macros for the landmark distance block
// used by landmark_mahalanobis_distance.sv, no other dependencies
`ifndef LANDMARK_MAHALANOBIS_DISTANCE_ASSERT_SVH
`define LANDMARK_MAHALANOBIS_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define LMD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmd assertion failed");
`define LMD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmd assertion failed");
`else
`define LMD_ASSERT_IMP(label, clk, rst, ante, cons)
`define LMD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/lmd_pkg.sv]
// shared types, constants and helper functions of the landmark distance block
// no dependencies; used by lmd_div and landmark_mahalanobis_distance
package lmd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 36;
  localparam int Z_W          = 21;
  localparam int NUM_W        = 53;
  localparam int DEN_W        = 32;
  localparam int QUO_W        = 33;
  localparam int DIV_LAT      = QUO_W + 1;
  localparam int PIPE_LEN     = 5 + CORDIC_STEPS + DIV_LAT;

  localparam logic signed [Z_W-1:0] Q16_PI = 21'sd205887;
  localparam logic signed [23:0] W_PI      = 24'sd205887;
  localparam logic signed [23:0] W_TWO_PI  = 24'sd411775;
  localparam logic signed [23:0] W_FOUR_PI = 24'sd823550;
  localparam logic [15:0] INV_GAIN         = 16'd39797;
  localparam logic [31:0] SAT32            = 32'hFFFF_FFFF;
  localparam logic [31:0] FLOOR_POS        = 32'd589824;
  localparam logic [31:0] FLOOR_HEAD       = 32'd294912;

  typedef enum logic [1:0] {
    REG_BEAR_SD    = 2'd0,
    REG_RANGE_SD   = 2'd1,
    REG_HEAD_SD    = 2'd2,
    REG_RANGE_GATE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [3:0]         flags;
    logic               gate_ok;
    logic               zero;
    logic [14:0]        obs_mm;
    logic signed [19:0] bsum;
    logic signed [20:0] craw;
  } side_t;

  typedef struct packed {
    logic        assoc;
    logic        use_pos;
    logic        use_head;
    logic [31:0] floor_q;
  } tail_t;

  typedef struct packed {
    logic             sat;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  function automatic logic signed [Z_W-1:0] cordic_atan(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      4'd0:  a = 21'sd51472;
      4'd1:  a = 21'sd30386;
      4'd2:  a = 21'sd16055;
      4'd3:  a = 21'sd8150;
      4'd4:  a = 21'sd4091;
      4'd5:  a = 21'sd2047;
      4'd6:  a = 21'sd1024;
      4'd7:  a = 21'sd512;
      4'd8:  a = 21'sd256;
      4'd9:  a = 21'sd128;
      4'd10: a = 21'sd64;
      4'd11: a = 21'sd32;
      4'd12: a = 21'sd16;
      4'd13: a = 21'sd8;
      4'd14: a = 21'sd4;
      4'd15: a = 21'sd2;
    endcase
    return a;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input logic [STEP_W-1:0] i);
    cordic_t n;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    xs = $signed(c.x) >>> i;
    ys = $signed(c.y) >>> i;
    if (!c.y[XY_W-1]) begin
      n.x = c.x + ys;
      n.y = c.y - xs;
      n.z = c.z + cordic_atan(i);
    end else begin
      n.x = c.x - ys;
      n.y = c.y + xs;
      n.z = c.z - cordic_atan(i);
    end
    return n;
  endfunction

  // input stays within three turns of zero, so a few compares replace the floor division
  function automatic logic signed [18:0] wrap_q16(input logic signed [22:0] v);
    logic signed [23:0] u;
    logic signed [23:0] w;
    u = $signed({v[22], v}) + W_PI;
    if (u >= W_FOUR_PI) begin
      w = u - W_FOUR_PI;
    end else if (u >= W_TWO_PI) begin
      w = u - W_TWO_PI;
    end else if (!u[23]) begin
      w = u;
    end else if (u >= -W_TWO_PI) begin
      w = u + W_TWO_PI;
    end else begin
      w = u + W_FOUR_PI;
    end
    w = w - W_PI;
    return w[18:0];
  endfunction

endpackage

[rtl/lmd_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on lmd_pkg
module lmd_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lmd_pkg::NUM_W-1:0]  num,
  input  logic [lmd_pkg::DEN_W-1:0]  den,
  output lmd_pkg::div_res_t          res
);

  logic [lmd_pkg::DEN_W-1:0] rem [0:lmd_pkg::QUO_W];
  logic [lmd_pkg::QUO_W-1:0] low [0:lmd_pkg::QUO_W];
  logic [lmd_pkg::DEN_W-1:0] dv  [0:lmd_pkg::QUO_W];
  logic                      dz  [0:lmd_pkg::QUO_W];
  logic                      st  [0:lmd_pkg::QUO_W];

  // quotient beyond the low bits means saturation; a zero divisor only saturates
  // a nonzero numerator
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= lmd_pkg::DEN_W'(num[lmd_pkg::NUM_W-1:lmd_pkg::QUO_W]);
      low[0] <= num[lmd_pkg::QUO_W-1:0];
      dv[0]  <= den;
      dz[0]  <= (den == '0);
      st[0]  <= (den == '0) ? (num != '0)
                : (lmd_pkg::DEN_W'(num[lmd_pkg::NUM_W-1:lmd_pkg::QUO_W]) >= den);
    end
  end

  for (genvar k = 1; k <= lmd_pkg::QUO_W; k++) begin : g_step
    logic [lmd_pkg::DEN_W:0] t;
    logic [lmd_pkg::DEN_W:0] d;
    logic                    ge;
    assign t  = {rem[k-1], low[k-1][lmd_pkg::QUO_W-1]};
    assign ge = (t >= {1'b0, dv[k-1]});
    assign d  = t - {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? d[lmd_pkg::DEN_W-1:0] : t[lmd_pkg::DEN_W-1:0];
        low[k] <= {low[k-1][lmd_pkg::QUO_W-2:0], ge};
        dv[k]  <= dv[k-1];
        dz[k]  <= dz[k-1];
        st[k]  <= st[k-1];
      end
    end
  end

  assign res.quo = dz[lmd_pkg::QUO_W] ? '0 : low[lmd_pkg::QUO_W];
  assign res.sat = st[lmd_pkg::QUO_W];

endmodule

[rtl/landmark_mahalanobis_distance.sv]
// one request per cycle sustained while the output is not stalled. the pipeline is made of
// the 16 CORDIC stages, the three 34-stage dividers running in parallel and six single
// stages around them.
// a stalled output freezes the whole pipeline.
// synchronous reset clears all stage valid bits and loads the register defaults.
// top level; depends on lmd_pkg, lmd_div and the assert macro header
`include "landmark_mahalanobis_distance_assert.svh"
module landmark_mahalanobis_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] particle_x,
  input  logic signed [15:0] particle_y,
  input  logic signed [15:0] particle_theta,
  input  logic signed [15:0] landmark_x,
  input  logic signed [15:0] landmark_y,
  input  logic signed [15:0] landmark_heading,
  input  logic [14:0]        obs_distance,
  input  logic signed [15:0] obs_bearing,
  input  logic signed [15:0] obs_heading,
  input  logic [3:0]         valid_flags,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        mahal_distance,
  output logic [31:0]        min_distance,
  output logic               no_association
);

  logic [13:0] bear_sd;
  logic [10:0] range_sd;
  logic [14:0] head_sd;
  logic [14:0] range_gate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bear_sd    <= 14'd1638;
      range_sd   <= 11'd500;
      head_sd    <= 15'd6434;
      range_gate <= 15'd4000;
    end else if (cfg_valid) begin
      unique case (lmd_pkg::cfg_reg_t'(cfg_index))
        lmd_pkg::REG_BEAR_SD:    bear_sd    <= cfg_data[13:0];
        lmd_pkg::REG_RANGE_SD:   range_sd   <= cfg_data[10:0];
        lmd_pkg::REG_HEAD_SD:    head_sd    <= cfg_data[14:0];
        lmd_pkg::REG_RANGE_GATE: range_gate <= cfg_data[14:0];
      endcase
    end
  end

  logic                          en;
  logic [lmd_pkg::PIPE_LEN-1:0]  vld;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[lmd_pkg::PIPE_LEN-2:0], in_valid};
      out_valid <= vld[lmd_pkg::PIPE_LEN-1];
    end
  end

  // stage 0: offsets and angle sums
  logic signed [16:0] s0_dx;
  logic signed [16:0] s0_dy;
  lmd_pkg::side_t     s0_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx           <= 17'(landmark_x) - 17'(particle_x);
      s0_dy           <= 17'(landmark_y) - 17'(particle_y);
      s0_side.flags   <= valid_flags;
      s0_side.gate_ok <= (obs_distance < range_gate);
      s0_side.zero    <= (landmark_x == particle_x) && (landmark_y == particle_y);
      s0_side.obs_mm  <= obs_distance;
      s0_side.bsum    <= (20'(obs_bearing) + 20'(particle_theta)) <<< 3;
      s0_side.craw    <= (21'(obs_heading) - 21'(landmark_heading)
                          + 21'(particle_theta)) <<< 3;
    end
  end

  // stage 1: fold the left half plane, then the rotation stages
  lmd_pkg::cordic_t cor [0:lmd_pkg::CORDIC_STEPS];
  lmd_pkg::side_t   sd  [0:lmd_pkg::CORDIC_STEPS];
  lmd_pkg::cordic_t pre;
  logic signed [lmd_pkg::XY_W-1:0] x0;
  logic signed [lmd_pkg::XY_W-1:0] y0;

  always_comb begin
    x0 = {{3{s0_dx[16]}}, s0_dx, 16'b0};
    y0 = {{3{s0_dy[16]}}, s0_dy, 16'b0};
    if (s0_dx[16]) begin
      pre.x = -x0;
      pre.y = -y0;
      pre.z = s0_dy[16] ? -lmd_pkg::Q16_PI : lmd_pkg::Q16_PI;
    end else begin
      pre.x = x0;
      pre.y = y0;
      pre.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor[0] <= pre;
      sd[0]  <= s0_side;
    end
  end

  for (genvar i = 0; i < lmd_pkg::CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        cor[i+1] <= lmd_pkg::cordic_step(cor[i], lmd_pkg::STEP_W'(i));
        sd[i+1]  <= sd[i];
      end
    end
  end

  // gain-corrected norm in q.8 mm
  logic signed [51:0] nprod;
  logic signed [26:0] n_norm;
  logic signed [lmd_pkg::Z_W-1:0] n_ang;
  lmd_pkg::side_t     n_side;

  assign nprod = 52'($signed(cor[lmd_pkg::CORDIC_STEPS].x))
               * 52'($signed({1'b0, lmd_pkg::INV_GAIN})) + 52'sd8388608;

  always_ff @(posedge clk) begin
    if (en) begin
      n_norm <= sd[lmd_pkg::CORDIC_STEPS].zero ? '0 : nprod[50:24];
      n_ang  <= sd[lmd_pkg::CORDIC_STEPS].zero ? '0 : cor[lmd_pkg::CORDIC_STEPS].z;
      n_side <= sd[lmd_pkg::CORDIC_STEPS];
    end
  end

  // innovations
  logic signed [18:0] i_b;
  logic signed [26:0] i_r;
  logic signed [18:0] i_c;
  lmd_pkg::side_t     i_side;

  always_ff @(posedge clk) begin
    if (en) begin
      i_b    <= lmd_pkg::wrap_q16(23'($signed(n_side.bsum)) - 23'(n_ang));
      i_r    <= $signed({4'b0, n_side.obs_mm, 8'b0}) - n_norm;
      i_c    <= lmd_pkg::wrap_q16(23'($signed(n_side.craw)));
      i_side <= n_side;
    end
  end

  // squares and variances
  logic [17:0] ab;
  logic [25:0] ar;
  logic [17:0] ac;
  logic [35:0] b_sq;
  logic [51:0] r_sq;
  logic [35:0] c_sq;
  logic [15:0] s4;

  assign ab   = i_b[18] ? 18'(-i_b) : 18'(i_b);
  assign ar   = i_r[26] ? 26'(-i_r) : 26'(i_r);
  assign ac   = i_c[18] ? 18'(-i_c) : 18'(i_c);
  assign b_sq = ab * ab;
  assign r_sq = ar * ar;
  assign c_sq = ac * ac;
  assign s4   = {3'b0, range_sd, 2'b0} + {1'b0, i_side.obs_mm};

  logic [lmd_pkg::NUM_W-1:0] sq_nb;
  logic [lmd_pkg::NUM_W-1:0] sq_nr;
  logic [lmd_pkg::NUM_W-1:0] sq_nc;
  logic [lmd_pkg::DEN_W-1:0] sq_db;
  logic [lmd_pkg::DEN_W-1:0] sq_dr;
  logic [lmd_pkg::DEN_W-1:0] sq_dc;
  lmd_pkg::tail_t            sq_tail;
  logic [3:0]                fl;

  assign fl = i_side.flags;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_nb            <= lmd_pkg::NUM_W'(b_sq) << 9;
      sq_nr            <= lmd_pkg::NUM_W'(r_sq) << 3;
      sq_nc            <= lmd_pkg::NUM_W'(c_sq) << 9;
      sq_db            <= lmd_pkg::DEN_W'(bear_sd * bear_sd);
      sq_dr            <= lmd_pkg::DEN_W'(s4 * s4);
      sq_dc            <= lmd_pkg::DEN_W'(head_sd * head_sd);
      sq_tail.assoc    <= fl[0];
      sq_tail.use_pos  <= fl[0] && fl[1] && i_side.gate_ok;
      sq_tail.use_head <= fl[0] && fl[2] && fl[3];
      sq_tail.floor_q  <= ((fl[0] && fl[1]) ? lmd_pkg::FLOOR_POS : '0)
                        + ((fl[0] && fl[2] && fl[3]) ? lmd_pkg::FLOOR_HEAD : '0);
    end
  end

  lmd_pkg::div_res_t res_b;
  lmd_pkg::div_res_t res_r;
  lmd_pkg::div_res_t res_c;

  lmd_div u_div_bearing (.clk(clk), .en(en), .num(sq_nb), .den(sq_db), .res(res_b));
  lmd_div u_div_range   (.clk(clk), .en(en), .num(sq_nr), .den(sq_dr), .res(res_r));
  lmd_div u_div_compass (.clk(clk), .en(en), .num(sq_nc), .den(sq_dc), .res(res_c));

  lmd_pkg::tail_t tl [0:lmd_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tl[0] <= sq_tail;
    end
  end

  for (genvar k = 1; k < lmd_pkg::DIV_LAT; k++) begin : g_tail
    always_ff @(posedge clk) begin
      if (en) begin
        tl[k] <= tl[k-1];
      end
    end
  end

  // sum of the used terms, then output register
  lmd_pkg::tail_t tf;
  logic [34:0]    sum;
  logic           sat;

  assign tf  = tl[lmd_pkg::DIV_LAT-1];
  assign sum = (tf.use_pos ? (35'(res_b.quo) + 35'(res_r.quo)) : 35'd0)
             + (tf.use_head ? 35'(res_c.quo) : 35'd0);
  assign sat = (tf.use_pos && (res_b.sat || res_r.sat))
             || (tf.use_head && res_c.sat)
             || (sum > 35'(lmd_pkg::SAT32));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!tf.assoc) begin
        mahal_distance <= lmd_pkg::SAT32;
        min_distance   <= lmd_pkg::SAT32;
        no_association <= 1'b1;
      end else begin
        mahal_distance <= sat ? lmd_pkg::SAT32 : sum[31:0];
        min_distance   <= tf.floor_q;
        no_association <= 1'b0;
      end
    end
  end

  `LMD_ASSERT_IMP(a_unassoc_all_ones, clk, rst, out_valid && no_association, (mahal_distance == lmd_pkg::SAT32) && (min_distance == lmd_pkg::SAT32))
  `LMD_ASSERT_IMP(a_floor_codes, clk, rst, out_valid && !no_association, (min_distance == 32'd0) || (min_distance == lmd_pkg::FLOOR_POS) || (min_distance == lmd_pkg::FLOOR_HEAD) || (min_distance == lmd_pkg::FLOOR_POS + lmd_pkg::FLOOR_HEAD))
  `LMD_ASSERT_IMP(a_no_floor_no_terms, clk, rst, out_valid && !no_association && (min_distance == 32'd0), mahal_distance == 32'd0)
  `LMD_ASSERT_NXT(a_stall_freezes, clk, rst, !en, $stable(vld) && out_valid)

endmodule
